// ===== hdl/two_harmonic_cosine_model_defines.svh =====
// Assertion macros shared by the two-harmonic cosine model RTL
`ifndef TWO_HARMONIC_COSINE_MODEL_DEFINES_SVH
`define TWO_HARMONIC_COSINE_MODEL_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define THCM_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("thcm check failed");

// next-cycle implication
`define THCM_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("thcm check failed");

`endif

// ===== hdl/thcm_pkg.sv =====
// Package: constants, register indexes and pipeline types of the cosine model
`default_nettype none
package thcm_pkg;
   localparam int ANGLE_BITS = 16;
   localparam int MAG_W      = 33;  // magnitude of a phase difference
   localparam int PER_W      = 31;  // period and remainder width
   localparam int ADDR_W     = 5;
   localparam int COS_LAT    = 10;  // register stages in thcm_cosine

   typedef enum logic [2:0] {
      REG_AMP1   = 3'd0,
      REG_OFF1   = 3'd1,
      REG_AMP2   = 3'd2,
      REG_OFF2   = 3'd3,
      REG_LEVEL  = 3'd4,
      REG_PERIOD = 3'd5
   } reg_index_type;

   localparam logic [30:0] Q30_ONE = 31'd1073741824;
   localparam logic [30:0] SIN_C1  = 31'd1686629713;
   localparam logic [30:0] SIN_C3  = 31'd693598668;
   localparam logic [30:0] SIN_C5  = 31'd85569306;
   localparam logic [30:0] SIN_C7  = 31'd5026994;
   localparam logic [30:0] SIN_C9  = 31'd172272;

   typedef struct packed {
      logic [MAG_W-1:0]      dvd;  // dividend bits still to shift in
      logic [PER_W-1:0]      rem;  // partial remainder, below the period
      logic [ANGLE_BITS-1:0] quo;  // quotient bits, newest at the bottom
      logic                  neg;  // phase difference was negative
   } lane_type;

   typedef struct packed {
      lane_type l1;
      lane_type l2;
   } cell_type;
endpackage
`default_nettype wire

// ===== hdl/two_harmonic_cosine_model.sv =====
// Top level: two-harmonic cosine model, one sample per cycle unless the output stalls
//
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/ready  | req_sample_time (Q16.16)
//  rsp     | out       | rsp_valid/ready  | rsp_model_value, rsp_saturated
//  apb     | in        | psel/penable     | paddr, pwdata, prdata
//
// One transaction per clock sustained while the output drains. Requests pass the
// front register, a cell chain of restoring division steps (MAG_W cells for the
// modulo, the fix register, ANGLE_BITS cells for the angle), thcm_cosine and the
// output register. The whole pipeline advances together; it stalls only while a
// result waits in the output register and rsp_ready is low.
// Synchronous reset clears the valid bits and loads the register reset values.
`default_nettype none
`include "two_harmonic_cosine_model_defines.svh"
module two_harmonic_cosine_model import thcm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [31:0]       req_sample_time,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [31:0]            rsp_model_value,
   output logic                   rsp_saturated,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   localparam int NMOD = MAG_W;
   localparam int NANG = ANGLE_BITS;

   // configuration registers
   logic signed [31:0] amp1_ff, off1_ff, amp2_ff, off2_ff, level_ff;
   logic [PER_W-1:0]   period_ff;
   logic [PER_W-1:0]   p_eff;
   reg_index_type      widx;
   logic               wr_en;

   assign pready = 1'b1;
   assign widx   = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign p_eff  = (period_ff == '0) ? PER_W'(1) : period_ff;  // zero period acts as one

   always_ff @(posedge clock) begin
      if (reset) begin
         amp1_ff   <= '0;
         off1_ff   <= '0;
         amp2_ff   <= '0;
         off2_ff   <= '0;
         level_ff  <= '0;
         period_ff <= PER_W'(65536);
      end else if (wr_en) begin
         unique case (widx)
            REG_AMP1:   amp1_ff   <= pwdata;
            REG_OFF1:   off1_ff   <= pwdata;
            REG_AMP2:   amp2_ff   <= pwdata;
            REG_OFF2:   off2_ff   <= pwdata;
            REG_LEVEL:  level_ff  <= pwdata;
            REG_PERIOD: period_ff <= pwdata[PER_W-1:0];
            default: ;  // unknown register: write dropped
         endcase
      end
   end

   always_comb begin
      unique case (widx)
         REG_AMP1:   prdata = amp1_ff;
         REG_OFF1:   prdata = off1_ff;
         REG_AMP2:   prdata = amp2_ff;
         REG_OFF2:   prdata = off2_ff;
         REG_LEVEL:  prdata = level_ff;
         REG_PERIOD: prdata = {1'b0, period_ff};
         default:    prdata = '0;
      endcase
   end

   // global advance: output register empty or being drained
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // front stage: phase differences as sign and magnitude
   logic signed [32:0] e1, e2;
   logic [32:0]        a1, a2;
   cell_type           front_in;
   cell_type           front_ff;
   logic               front_vld_ff;

   always_comb begin
      e1 = 33'(signed'(req_sample_time)) - 33'(off1_ff);
      e2 = 33'(signed'(req_sample_time)) - 33'(off2_ff);
      a1 = e1[32] ? 33'(-e1) : 33'(e1);
      a2 = e2[32] ? 33'(-e2) : 33'(e2);
      front_in.l1.dvd = a1;
      front_in.l1.rem = '0;
      front_in.l1.quo = '0;
      front_in.l1.neg = e1[32];
      front_in.l2.dvd = {a2[31:0], 1'b0};  // second harmonic: difference doubled
      front_in.l2.rem = '0;
      front_in.l2.quo = '0;
      front_in.l2.neg = e2[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else if (adv) begin
         front_vld_ff <= req_valid;
      end
      if (adv) begin
         front_ff <= front_in;
      end
   end

   // modulo chain: after NMOD cells rem holds |d| mod period
   logic     mod_vld [0:NMOD];
   cell_type mod_dat [0:NMOD];
   assign mod_vld[0] = front_vld_ff;
   assign mod_dat[0] = front_ff;

   for (genvar g = 0; g < NMOD; g++) begin : g_mod
      thcm_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .period (p_eff),
         .vld_in (mod_vld[g]),
         .dat_in (mod_dat[g]),
         .vld_ff (mod_vld[g+1]),
         .dat_ff (mod_dat[g+1])
      );
   end

   // floor-modulo fix for negative differences, then angle chain setup
   cell_type fix_in;
   cell_type fix_ff;
   logic     fix_vld_ff;
   logic [PER_W-1:0] m1, m2;

   always_comb begin
      m1 = mod_dat[NMOD].l1.rem;
      m2 = mod_dat[NMOD].l2.rem;
      fix_in.l1.rem = (mod_dat[NMOD].l1.neg && m1 != '0) ? p_eff - m1 : m1;
      fix_in.l2.rem = (mod_dat[NMOD].l2.neg && m2 != '0) ? p_eff - m2 : m2;
      fix_in.l1.dvd = '0;
      fix_in.l2.dvd = '0;
      fix_in.l1.quo = '0;
      fix_in.l2.quo = '0;
      fix_in.l1.neg = 1'b0;
      fix_in.l2.neg = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_vld_ff <= 1'b0;
      end else if (adv) begin
         fix_vld_ff <= mod_vld[NMOD];
      end
      if (adv) begin
         fix_ff <= fix_in;
      end
   end

   // angle chain: shifting in zeros gives floor(r * 2^ANGLE_BITS / period)
   logic     ang_vld [0:NANG];
   cell_type ang_dat [0:NANG];
   assign ang_vld[0] = fix_vld_ff;
   assign ang_dat[0] = fix_ff;

   for (genvar g = 0; g < NANG; g++) begin : g_ang
      thcm_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .period (p_eff),
         .vld_in (ang_vld[g]),
         .dat_in (ang_dat[g]),
         .vld_ff (ang_vld[g+1]),
         .dat_ff (ang_dat[g+1])
      );
   end

   // cosine and amplitude per harmonic
   logic signed [33:0] term1, term2;
   logic [COS_LAT-1:0] cos_vld_ff;

   thcm_cosine u_cos1 (
      .clock   (clock),
      .adv     (adv),
      .angle   (ang_dat[NANG].l1.quo),
      .amp     (amp1_ff),
      .term_ff (term1)
   );

   thcm_cosine u_cos2 (
      .clock   (clock),
      .adv     (adv),
      .angle   (ang_dat[NANG].l2.quo),
      .amp     (amp2_ff),
      .term_ff (term2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_vld_ff <= '0;
      end else if (adv) begin
         cos_vld_ff <= {cos_vld_ff[COS_LAT-2:0], ang_vld[NANG]};
      end
   end

   // sum, saturate, output register
   logic signed [34:0] sum;
   logic [31:0]        val_in;
   logic               sat_in;
   logic [31:0]        rsp_value_ff;
   logic               rsp_sat_ff;

   always_comb begin
      sum = 35'(term1) + 35'(term2) + 35'(level_ff);
      if (sum > 35'sd2147483647) begin
         val_in = 32'h7FFF_FFFF;
         sat_in = 1'b1;
      end else if (sum < -35'sd2147483648) begin
         val_in = 32'h8000_0000;
         sat_in = 1'b1;
      end else begin
         val_in = sum[31:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cos_vld_ff[COS_LAT-1];
      end
      if (adv) begin
         rsp_value_ff <= val_in;
         rsp_sat_ff   <= sat_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_model_value = rsp_value_ff;
   assign rsp_saturated   = rsp_sat_ff;

   `THCM_IMPLY(a_sat_at_limit, rsp_valid_ff && rsp_sat_ff, (rsp_value_ff == 32'h7FFF_FFFF) || (rsp_value_ff == 32'h8000_0000))
   `THCM_NEXT(a_result_lands, cos_vld_ff[COS_LAT-1] && adv, rsp_valid_ff)
endmodule
`default_nettype wire

// ===== hdl/thcm_cell.sv =====
// One restoring-division cell: one quotient bit per lane per cycle while adv is high
`default_nettype none
`include "two_harmonic_cosine_model_defines.svh"
module thcm_cell import thcm_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic [PER_W-1:0] period,
   input  wire logic             vld_in,
   input  wire cell_type         dat_in,
   output logic                  vld_ff,
   output cell_type              dat_ff
);
   function automatic lane_type lane_step(lane_type a, logic [PER_W-1:0] p);
      logic [PER_W:0] trial;
      logic           q;
      lane_type       b;
      b     = a;
      trial = {a.rem, a.dvd[MAG_W-1]};
      q     = (trial >= {1'b0, p});
      b.rem = q ? PER_W'(trial - {1'b0, p}) : trial[PER_W-1:0];
      b.dvd = {a.dvd[MAG_W-2:0], 1'b0};
      b.quo = {a.quo[ANGLE_BITS-2:0], q};
      return b;
   endfunction

   logic     vld_in_w;
   cell_type dat_in_w;

   always_comb begin
      vld_in_w    = vld_in;
      dat_in_w.l1 = lane_step(dat_in.l1, period);
      dat_in_w.l2 = lane_step(dat_in.l2, period);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in_w;
      end
      if (adv) begin
         dat_ff <= dat_in_w;
      end
   end

   `THCM_IMPLY(a_rem_below_period, vld_ff, (dat_ff.l1.rem < period) && (dat_ff.l2.rem < period))
   `THCM_NEXT(a_cell_holds_on_stall, !adv, vld_ff == $past(vld_ff))
endmodule
`default_nettype wire

// ===== hdl/thcm_cosine.sv =====
// Cosine of a turn angle by quarter-sine polynomial, scaled by an amplitude
`default_nettype none
module thcm_cosine import thcm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  adv,
   input  wire logic [ANGLE_BITS-1:0] angle,
   input  wire logic signed [31:0]    amp,
   output logic signed [33:0]         term_ff
);
   logic [30:0]        u_ff   [0:5];
   logic               neg_ff [0:6];
   logic [30:0]        u2_ff  [1:4];
   logic [30:0]        acc_ff [2:6];
   logic signed [31:0] c_ff;
   logic signed [63:0] prod_ff;

   logic [1:0]         quad;
   logic [29:0]        x;
   logic [30:0]        u_in;
   logic [61:0]        sq;
   logic [61:0]        m2, m3, m4, m5, m6;
   logic [30:0]        acc6_in;
   logic signed [31:0] c_in;
   logic signed [63:0] rnd;

   always_comb begin
      quad    = angle[ANGLE_BITS-1 -: 2];
      x       = {angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
      u_in    = quad[0] ? {1'b0, x} : Q30_ONE - {1'b0, x};
      sq      = 62'(u_ff[0]) * 62'(u_ff[0]);
      m2      = 62'(u2_ff[1]) * 62'(SIN_C9);
      m3      = 62'(u2_ff[2]) * 62'(acc_ff[2]);
      m4      = 62'(u2_ff[3]) * 62'(acc_ff[3]);
      m5      = 62'(u2_ff[4]) * 62'(acc_ff[4]);
      m6      = 62'(u_ff[5]) * 62'(acc_ff[5]);
      acc6_in = (m6[60:30] > Q30_ONE) ? Q30_ONE : m6[60:30];
      c_in    = neg_ff[6] ? -$signed({1'b0, acc_ff[6]}) : $signed({1'b0, acc_ff[6]});
      rnd     = prod_ff + 64'sd536870912;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff[0]   <= u_in;
         neg_ff[0] <= quad[1] ^ quad[0];
         for (int i = 1; i <= 5; i++) begin
            u_ff[i] <= u_ff[i-1];
         end
         for (int i = 1; i <= 6; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         u2_ff[1] <= sq[60:30];
         for (int i = 2; i <= 4; i++) begin
            u2_ff[i] <= u2_ff[i-1];
         end
         acc_ff[2] <= SIN_C7 - m2[60:30];
         acc_ff[3] <= SIN_C5 - m3[60:30];
         acc_ff[4] <= SIN_C3 - m4[60:30];
         acc_ff[5] <= SIN_C1 - m5[60:30];
         acc_ff[6] <= acc6_in;
         c_ff      <= c_in;
         prod_ff   <= 64'(amp) * 64'(c_ff);
         term_ff   <= rnd[63:30];
      end
   end
endmodule
`default_nettype wire
